// ===== design/bda_pkg.sv =====
// ---------------------------------------------------------------------------
// bda_pkg: shared types and constants for the button debouncer
// Register map, reset values, field widths and the timing bundle that the
// register block hands to the sequencer.
// ---------------------------------------------------------------------------
package bda_pkg;

   // default geometry
   localparam int BDA_NUM_BUTTONS = 4;
   localparam int BDA_TIME_BITS   = 16;

   // register field widths
   localparam int CFG_W   = 16;
   localparam int ACCEL_W = 8;

   // divider widths: product of interval span and step count, and quotient
   localparam int PROD_W = CFG_W + ACCEL_W;
   localparam int QUO_W  = CFG_W;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // interval floor
   localparam logic [CFG_W-1:0] MIN_FAST = CFG_W'(20);

   // register reset values
   localparam logic [CFG_W-1:0]   RST_DEBOUNCE = CFG_W'(20);
   localparam logic [CFG_W-1:0]   RST_DELAY    = CFG_W'(450);
   localparam logic [CFG_W-1:0]   RST_SLOW     = CFG_W'(160);
   localparam logic [CFG_W-1:0]   RST_FAST     = CFG_W'(45);
   localparam logic [ACCEL_W-1:0] RST_ACCEL    = ACCEL_W'(12);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MASK,
      REG_DEBOUNCE,
      REG_DELAY,
      REG_SLOW,
      REG_FAST,
      REG_ACCEL
   } reg_idx_type;

   // timing registers as seen by the sequencer
   typedef struct packed {
      logic [CFG_W-1:0]   debounce;
      logic [CFG_W-1:0]   repeat_delay;
      logic [CFG_W-1:0]   slow_interval;
      logic [CFG_W-1:0]   fast_interval;
      logic [ACCEL_W-1:0] accel_steps;
   } timing_type;

endpackage

// ===== design/bda_req_if.sv =====
// ---------------------------------------------------------------------------
// bda_req_if: tick channel
// One beat per millisecond tick, carrying the raw level of every button.
// ---------------------------------------------------------------------------
interface bda_req_if #(
   parameter int NUM_BUTTONS = bda_pkg::BDA_NUM_BUTTONS
);
   logic                   valid;
   logic                   ready;
   logic [NUM_BUTTONS-1:0] raw_levels;

   modport source (output valid, output raw_levels, input ready);
   modport sink   (input valid, input raw_levels, output ready);
endinterface

// ===== design/bda_rsp_if.sv =====
// ---------------------------------------------------------------------------
// bda_rsp_if: event channel
// One beat per tick with press, release and repeat pulses and stable levels.
// ---------------------------------------------------------------------------
interface bda_rsp_if #(
   parameter int NUM_BUTTONS = bda_pkg::BDA_NUM_BUTTONS
);
   logic                   valid;
   logic                   ready;
   logic [NUM_BUTTONS-1:0] press_pulses;
   logic [NUM_BUTTONS-1:0] release_pulses;
   logic [NUM_BUTTONS-1:0] repeat_pulses;
   logic [NUM_BUTTONS-1:0] stable_levels;

   modport source (output valid, output press_pulses, output release_pulses,
                   output repeat_pulses, output stable_levels, input ready);
   modport sink   (input valid, input press_pulses, input release_pulses,
                   input repeat_pulses, input stable_levels, output ready);
endinterface

// ===== design/bda_csr.sv =====
// ---------------------------------------------------------------------------
// bda_csr: configuration registers
// APB-style register block holding polarity mask, debounce and repeat timing.
// ---------------------------------------------------------------------------
module bda_csr #(
   parameter int NUM_BUTTONS = bda_pkg::BDA_NUM_BUTTONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bda_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bda_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bda_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [NUM_BUTTONS-1:0]          mask,
   output bda_pkg::timing_type             timing
);
   import bda_pkg::*;

   logic [NUM_BUTTONS-1:0] mask_ff;
   timing_type             timing_ff;
   reg_idx_type            reg_idx;
   logic                   wr_en;

   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign mask    = mask_ff;
   assign timing  = timing_ff;

   // write registers; unknown indexes drop the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff                 <= '0;
         timing_ff.debounce      <= RST_DEBOUNCE;
         timing_ff.repeat_delay  <= RST_DELAY;
         timing_ff.slow_interval <= RST_SLOW;
         timing_ff.fast_interval <= RST_FAST;
         timing_ff.accel_steps   <= RST_ACCEL;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MASK:     mask_ff                 <= pwdata[NUM_BUTTONS-1:0];
            REG_DEBOUNCE: timing_ff.debounce      <= pwdata[CFG_W-1:0];
            REG_DELAY:    timing_ff.repeat_delay  <= pwdata[CFG_W-1:0];
            REG_SLOW:     timing_ff.slow_interval <= pwdata[CFG_W-1:0];
            REG_FAST:     timing_ff.fast_interval <= pwdata[CFG_W-1:0];
            REG_ACCEL:    timing_ff.accel_steps   <= pwdata[ACCEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_MASK:     prdata = CSR_DATA_W'(mask_ff);
         REG_DEBOUNCE: prdata = CSR_DATA_W'(timing_ff.debounce);
         REG_DELAY:    prdata = CSR_DATA_W'(timing_ff.repeat_delay);
         REG_SLOW:     prdata = CSR_DATA_W'(timing_ff.slow_interval);
         REG_FAST:     prdata = CSR_DATA_W'(timing_ff.fast_interval);
         REG_ACCEL:    prdata = CSR_DATA_W'(timing_ff.accel_steps);
         default:      prdata = '0;
      endcase
   end

endmodule

// ===== design/bda_div.sv =====
// ---------------------------------------------------------------------------
// bda_div: shared restoring divider
// Divides the interval-span product by the step count, one quotient bit per
// cycle. The top divisor-width bits of the dividend must be below the divisor.
// ---------------------------------------------------------------------------
module bda_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bda_pkg::PROD_W-1:0]    dividend,
   input  logic [bda_pkg::ACCEL_W-1:0]   divisor,
   output logic                          done,
   output logic [bda_pkg::QUO_W-1:0]     quotient
);
   import bda_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [ACCEL_W-1:0] rem_ff;
   logic [ACCEL_W-1:0] div_ff;
   logic [QUO_W-1:0]   quo_ff;

   logic [ACCEL_W:0]   partial;
   logic [ACCEL_W:0]   diff;
   logic               q_bit;

   // one trial subtraction per cycle
   always_comb begin
      partial = {rem_ff, quo_ff[QUO_W-1]};
      diff    = partial - {1'b0, div_ff};
      q_bit   = (partial >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // load operands, then shift in the low dividend bits as quotient bits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[PROD_W-1 -: ACCEL_W];
         quo_ff <= dividend[QUO_W-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= q_bit ? diff[ACCEL_W-1:0] : partial[ACCEL_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], q_bit};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/button_debounce_autorepeat.sv =====
// Sequencing: each tick walks every button through the evaluate state; each
//   button that needs an accelerated interval adds a multiply and a 16-step divide.
// Flow: a new tick is taken only once the previous one has gone to the output
//   register; the per-button sequencer and the shared bit-serial divider set the pace.
// Reset: synchronous, active high; clears all button state, loads register
//   defaults; request ready is combinational and rises as reset drops.
// ---------------------------------------------------------------------------
// button_debounce_autorepeat: debouncer with accelerating auto-repeat
// Walks the buttons one at a time per tick, updating debounce and hold
// counters, and computes the shrinking repeat interval on a shared divider.
// ---------------------------------------------------------------------------
module button_debounce_autorepeat #(
   parameter int NUM_BUTTONS = bda_pkg::BDA_NUM_BUTTONS,
   parameter int TIME_BITS   = bda_pkg::BDA_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   bda_req_if.sink                         req_bus,
   bda_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bda_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bda_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bda_pkg::*;

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MULT,
      ST_DSTART,
      ST_DWAIT,
      ST_FIN,
      ST_DONE
   } state_type;

   // configuration
   logic [NUM_BUTTONS-1:0] mask;
   timing_type             timing;

   // sequencer
   state_type              state_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [NUM_BUTTONS-1:0] levels_ff;
   logic [ACCEL_W-1:0]     steps_ff;
   logic [PROD_W-1:0]      product_ff;

   // per-button state
   logic [NUM_BUTTONS-1:0] last_raw_ff;
   logic [NUM_BUTTONS-1:0] stable_ff;
   logic [NUM_BUTTONS-1:0] held_ff;
   logic [TIME_BITS-1:0]   settle_ff    [NUM_BUTTONS];
   logic [TIME_BITS-1:0]   held_time_ff [NUM_BUTTONS];
   logic [TIME_BITS-1:0]   since_ff     [NUM_BUTTONS];
   logic [TIME_BITS-1:0]   total_ff     [NUM_BUTTONS];

   // tick results being built and the output register
   logic [NUM_BUTTONS-1:0] press_ff;
   logic [NUM_BUTTONS-1:0] release_ff;
   logic [NUM_BUTTONS-1:0] repeat_ff;
   logic                   rsp_valid_ff;
   logic [NUM_BUTTONS-1:0] rsp_press_ff;
   logic [NUM_BUTTONS-1:0] rsp_release_ff;
   logic [NUM_BUTTONS-1:0] rsp_repeat_ff;
   logic [NUM_BUTTONS-1:0] rsp_stable_ff;

   // combinational per-button update
   logic                   raw_bit;
   logic                   change;
   logic                   stable_in;
   logic                   held_in;
   logic [TIME_BITS-1:0]   settle_in;
   logic [TIME_BITS-1:0]   held_time_in;
   logic [TIME_BITS-1:0]   since_in;
   logic [TIME_BITS-1:0]   total_in;
   logic [ACCEL_W-1:0]     steps_in;
   logic [CFG_W-1:0]       fast_c;
   logic [CFG_W-1:0]       slow_c;
   logic [CFG_W-1:0]       span;
   logic [CFG_W-1:0]       accel_interval;
   logic                   accel_on;
   logic                   rep_check;
   logic                   need_div;
   logic                   fire_fast;
   logic                   fire_div;
   logic                   last_btn;

   // divider handshake
   logic                   div_start;
   logic                   div_done;
   logic [QUO_W-1:0]       div_quo;

   function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   bda_csr #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .mask    (mask),
      .timing  (timing)
   );

   bda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (timing.accel_steps),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign div_start = (state_ff == ST_DSTART);
   assign last_btn  = (idx_ff == LAST_IDX);

   // clamp intervals and decide whether acceleration applies
   always_comb begin
      fast_c   = (timing.fast_interval < MIN_FAST) ? MIN_FAST : timing.fast_interval;
      slow_c   = (timing.slow_interval < fast_c) ? fast_c : timing.slow_interval;
      span     = slow_c - fast_c;
      accel_on = (timing.accel_steps != '0) && (slow_c > fast_c);
      accel_interval = slow_c - div_quo;
   end

   // debounce and hold update for the current button
   always_comb begin
      raw_bit = levels_ff[idx_ff] ^ mask[idx_ff];
      settle_in = (raw_bit != last_raw_ff[idx_ff]) ? '0 : sat_inc(settle_ff[idx_ff]);
      change = (CMP_W'(settle_in) >= CMP_W'(timing.debounce)) &&
               (stable_ff[idx_ff] != raw_bit);
      stable_in = change ? raw_bit : stable_ff[idx_ff];
      held_in   = change ? raw_bit : held_ff[idx_ff];
      if (change) begin
         held_time_in = '0;
         since_in     = '0;
         total_in     = '0;
      end else begin
         held_time_in = held_ff[idx_ff] ? sat_inc(held_time_ff[idx_ff])
                                        : held_time_ff[idx_ff];
         since_in     = held_ff[idx_ff] ? sat_inc(since_ff[idx_ff]) : since_ff[idx_ff];
         total_in     = total_ff[idx_ff];
      end
      if (CMP_W'(total_in) >= CMP_W'(timing.accel_steps)) begin
         steps_in = timing.accel_steps;
      end else begin
         steps_in = total_in[ACCEL_W-1:0];
      end
      rep_check = stable_in && held_in &&
                  (CMP_W'(held_time_in) >= CMP_W'(timing.repeat_delay));
      need_div  = rep_check && accel_on;
      fire_fast = rep_check && !accel_on && (CMP_W'(since_in) >= CMP_W'(fast_c));
      fire_div  = CMP_W'(since_ff[idx_ff]) >= CMP_W'(accel_interval);
   end

   // sequencer, button state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_raw_ff  <= '0;
         stable_ff    <= '0;
         held_ff      <= '0;
         press_ff     <= '0;
         release_ff   <= '0;
         repeat_ff    <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            settle_ff[i]    <= '0;
            held_time_ff[i] <= '0;
            since_ff[i]     <= '0;
            total_ff[i]     <= '0;
         end
      end else begin
         // drop the output beat once taken, unless a new one loads now
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  levels_ff  <= req_bus.raw_levels;
                  idx_ff     <= '0;
                  press_ff   <= '0;
                  release_ff <= '0;
                  repeat_ff  <= '0;
                  state_ff   <= ST_EVAL;
               end
            end

            ST_EVAL: begin
               last_raw_ff[idx_ff]  <= raw_bit;
               settle_ff[idx_ff]    <= settle_in;
               stable_ff[idx_ff]    <= stable_in;
               held_ff[idx_ff]      <= held_in;
               held_time_ff[idx_ff] <= held_time_in;
               since_ff[idx_ff]     <= fire_fast ? '0 : since_in;
               total_ff[idx_ff]     <= fire_fast ? sat_inc(total_in) : total_in;
               press_ff[idx_ff]     <= change && raw_bit;
               release_ff[idx_ff]   <= change && !raw_bit;
               repeat_ff[idx_ff]    <= (change && raw_bit) || fire_fast;
               steps_ff             <= steps_in;
               if (need_div) begin
                  state_ff <= ST_MULT;
               end else if (last_btn) begin
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            ST_MULT: begin
               product_ff <= PROD_W'(span) * PROD_W'(steps_ff);
               state_ff   <= ST_DSTART;
            end

            ST_DSTART: begin
               state_ff <= ST_DWAIT;
            end

            ST_DWAIT: begin
               if (div_done) begin
                  state_ff <= ST_FIN;
               end
            end

            ST_FIN: begin
               if (fire_div) begin
                  since_ff[idx_ff]  <= '0;
                  total_ff[idx_ff]  <= sat_inc(total_ff[idx_ff]);
                  repeat_ff[idx_ff] <= 1'b1;
               end
               if (last_btn) begin
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_EVAL;
               end
            end

            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_press_ff   <= press_ff;
                  rsp_release_ff <= release_ff;
                  rsp_repeat_ff  <= repeat_ff;
                  rsp_stable_ff  <= stable_ff;
                  state_ff       <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready          = (state_ff == ST_IDLE) && !reset;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.press_pulses   = rsp_press_ff;
   assign rsp_bus.release_pulses = rsp_release_ff;
   assign rsp_bus.repeat_pulses  = rsp_repeat_ff;
   assign rsp_bus.stable_levels  = rsp_stable_ff;

endmodule
